>>> rtl/lavm_pkg.sv
// Shared types and constants for the look-at view matrix unit.
// Depends on nothing; imported by lavm_unitize, look_at_view_matrix_unit and the testbench.
package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    // magnitude bits kept after normalisation: largest lies in [2^29, 2^30)
    localparam int MAG_W         = 30;
    // root bits resolved per square-root stage, quotient bits per divider stage
    localparam int SQ_IT         = 4;
    localparam int DV_IT         = 4;

    localparam logic [1:0] GROUP_LAST = 2'd3;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_flow;

    typedef struct packed {
        logic signed [COORD_W-1:0] eye_x;
        logic signed [COORD_W-1:0] eye_y;
        logic signed [COORD_W-1:0] eye_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                group_index;
        logic signed [COORD_W-1:0] value_0;
        logic signed [COORD_W-1:0] value_1;
        logic signed [COORD_W-1:0] value_2;
        logic signed [COORD_W-1:0] value_3;
        logic                      last_group;
        logic                      degenerate;
    } t_out_item;

endpackage

>>> rtl/lavm_unitize.sv
// Pipelined 3-vector normaliser: common power-of-two scaling, sum of squares,
// digit-by-digit square root and restoring division. Depends on lavm_pkg.
module lavm_unitize
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IN_W      = COORD_W + 1,
    parameter int SIDE_W    = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_flow                     i_flow,
    input  logic [2:0][IN_W-1:0]      i_vec,
    input  logic [SIDE_W-1:0]         i_side,
    output t_flow                     o_flow,
    output logic [2:0][FRAC_BITS+1:0] o_unit,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int UW     = FRAC_BITS + 2;
    localparam int NW     = (IN_W < 32) ? 32 : IN_W;
    localparam int SW     = $clog2(NW);
    localparam int SH1    = (SW + 1) / 2;
    localparam int SQW    = 2 * MAG_W;
    localparam int SUMW   = SQW + 2;
    localparam int ROOT_W = MAG_W + 1;
    localparam int SRW    = ROOT_W + 3;
    localparam int SQ_ST  = (ROOT_W + SQ_IT - 1) / SQ_IT;
    localparam int QW     = FRAC_BITS + 1;
    localparam int NUM_W  = MAG_W + QW;
    localparam int RW     = ROOT_W + 1;
    localparam int DV_ST  = (QW + DV_IT - 1) / DV_IT;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [2:0]        neg;
        logic [SIDE_W-1:0] side;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic [2:0][NW-1:0] mag;
    } t_mag;

    typedef struct packed {
        t_tag               tag;
        logic [2:0][NW-1:0] mag;
        logic [NW-1:0]      om;
    } t_norm;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][MAG_W-1:0] m;
    } t_m30;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][MAG_W-1:0] m;
        logic [2:0][SQW-1:0]   sq;
    } t_sq;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][MAG_W-1:0] m;
        logic [SUMW-1:0]       x;
        logic [ROOT_W-1:0]     root;
        logic [SRW-1:0]        rem;
    } t_root;

    typedef struct packed {
        t_tag               tag;
        logic [ROOT_W-1:0]  len;
        logic [2:0][QW-1:0] lo;
        logic [2:0][RW-1:0] rem;
        logic [2:0][QW-1:0] q;
    } t_div;

    typedef struct packed {
        t_tag               tag;
        logic [2:0][UW-1:0] u;
    } t_out;

    t_mag  r_a,  n_a;
    t_norm r_b,  n_b;
    t_m30  r_c,  n_c;
    t_sq   r_d,  n_d;
    t_root r_rt [SQ_ST+1];
    t_root n_rt [SQ_ST+1];
    t_div  r_dv [DV_ST+1];
    t_div  n_dv [DV_ST+1];
    t_out  r_o,  n_o;

    // magnitudes and signs
    always_comb begin
        logic [IN_W-1:0] m;
        n_a.tag.valid = i_flow.valid;
        n_a.tag.ok    = i_flow.ok;
        n_a.tag.side  = i_side;
        for (int j = 0; j < 3; j++) begin
            n_a.tag.neg[j] = i_vec[j][IN_W-1];
            m = i_vec[j][IN_W-1] ? (~i_vec[j] + 1'b1) : i_vec[j];
            n_a.mag[j] = NW'(m);
        end
    end

    // left-align the common leading one, coarse steps first
    always_comb begin
        logic [NW-1:0]      om;
        logic [2:0][NW-1:0] mg;
        om = r_a.mag[0] | r_a.mag[1] | r_a.mag[2];
        mg = r_a.mag;
        n_b.tag    = r_a.tag;
        n_b.tag.ok = r_a.tag.ok && (om != '0);
        for (int k = SW - 1; k >= SW - SH1; k--) begin
            if ((om >> (NW - (1 << k))) == '0) begin
                om = om << (1 << k);
                for (int j = 0; j < 3; j++) mg[j] = mg[j] << (1 << k);
            end
        end
        n_b.mag = mg;
        n_b.om  = om;
    end

    always_comb begin
        logic [NW-1:0]      om;
        logic [2:0][NW-1:0] mg;
        om = r_b.om;
        mg = r_b.mag;
        for (int k = SW - SH1 - 1; k >= 0; k--) begin
            if ((om >> (NW - (1 << k))) == '0) begin
                om = om << (1 << k);
                for (int j = 0; j < 3; j++) mg[j] = mg[j] << (1 << k);
            end
        end
        n_c.tag = r_b.tag;
        for (int j = 0; j < 3; j++) n_c.m[j] = mg[j][NW-1 -: MAG_W];
    end

    always_comb begin
        n_d.tag = r_c.tag;
        n_d.m   = r_c.m;
        for (int j = 0; j < 3; j++) n_d.sq[j] = SQW'(r_c.m[j]) * SQW'(r_c.m[j]);
    end

    // sum of squares, then two radicand bits per root step
    always_comb begin
        t_root            cur;
        logic [SRW-1:0]   rem2;
        logic [SRW-1:0]   trial;
        n_rt[0].tag  = r_d.tag;
        n_rt[0].m    = r_d.m;
        n_rt[0].x    = SUMW'(r_d.sq[0]) + SUMW'(r_d.sq[1]) + SUMW'(r_d.sq[2]);
        n_rt[0].root = '0;
        n_rt[0].rem  = '0;
        for (int s = 1; s <= SQ_ST; s++) begin
            cur = r_rt[s-1];
            for (int t = 0; t < SQ_IT; t++) begin
                if ((s - 1) * SQ_IT + t < ROOT_W) begin
                    rem2  = {cur.rem[SRW-3:0], cur.x[SUMW-1 -: 2]};
                    trial = SRW'({cur.root, 2'b01});
                    cur.x = cur.x << 2;
                    if (rem2 >= trial) begin
                        cur.rem  = rem2 - trial;
                        cur.root = {cur.root[ROOT_W-2:0], 1'b1};
                    end else begin
                        cur.rem  = rem2;
                        cur.root = {cur.root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            n_rt[s] = cur;
        end
    end

    // rounded numerator, then one quotient bit per divider step
    always_comb begin
        t_div             cur;
        logic [NUM_W-1:0] num;
        logic [RW-1:0]    rem2;
        logic             ge;
        n_dv[0].tag = r_rt[SQ_ST].tag;
        n_dv[0].len = r_rt[SQ_ST].root;
        for (int j = 0; j < 3; j++) begin
            num = (NUM_W'(r_rt[SQ_ST].m[j]) << FRAC_BITS)
                + NUM_W'(r_rt[SQ_ST].root >> 1);
            n_dv[0].lo[j]  = num[QW-1:0];
            n_dv[0].rem[j] = RW'(num[NUM_W-1:QW]);
            n_dv[0].q[j]   = '0;
        end
        for (int s = 1; s <= DV_ST; s++) begin
            cur = r_dv[s-1];
            for (int j = 0; j < 3; j++) begin
                for (int t = 0; t < DV_IT; t++) begin
                    if ((s - 1) * DV_IT + t < QW) begin
                        rem2       = {cur.rem[j][RW-2:0], cur.lo[j][QW-1]};
                        cur.lo[j]  = cur.lo[j] << 1;
                        ge         = rem2 >= RW'(cur.len);
                        cur.rem[j] = ge ? (rem2 - RW'(cur.len)) : rem2;
                        cur.q[j]   = {cur.q[j][QW-2:0], ge};
                    end
                end
            end
            n_dv[s] = cur;
        end
    end

    always_comb begin
        logic [UW-1:0] qq;
        n_o.tag = r_dv[DV_ST].tag;
        for (int j = 0; j < 3; j++) begin
            qq = UW'(r_dv[DV_ST].q[j]);
            n_o.u[j] = r_dv[DV_ST].tag.neg[j] ? (~qq + 1'b1) : qq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.tag.valid <= 1'b0;
            r_b.tag.valid <= 1'b0;
            r_c.tag.valid <= 1'b0;
            r_d.tag.valid <= 1'b0;
            for (int s = 0; s <= SQ_ST; s++) r_rt[s].tag.valid <= 1'b0;
            for (int s = 0; s <= DV_ST; s++) r_dv[s].tag.valid <= 1'b0;
            r_o.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_a  <= n_a;
            r_b  <= n_b;
            r_c  <= n_c;
            r_d  <= n_d;
            r_rt <= n_rt;
            r_dv <= n_dv;
            r_o  <= n_o;
        end
    end

    assign o_flow.valid = r_o.tag.valid;
    assign o_flow.ok    = r_o.tag.ok;
    assign o_unit       = r_o.u;
    assign o_side       = r_o.tag.side;

endmodule

>>> rtl/look_at_view_matrix_unit.sv
// Look-at view matrix unit: top level, pipeline glue, dot products, output groups.
// Depends on lavm_pkg and lavm_unitize.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one item: eye and target
//   points, signed fixed point with FRAC_BITS fraction bits. Output channel
//   o_out_valid / i_out_ready carries four groups per item, group 0 to 3, of
//   the column-major view matrix; last_group marks group 3.
//   An item passes the input register, the forward and right normalisers, the
//   cross-product registers, the up normaliser, the dot-product, rounding and
//   saturation registers and the output register; groups follow on consecutive
//   cycles while the receiver takes them. All four groups of an item leave through
//   the single output register, which loads the next as the last group is taken.
//   The pipeline holds when the output register is full and its last group is
//   not being taken; nothing is dropped or repeated during a stall.
//   Reset (synchronous, active low) empties the pipeline and output register.
//   A zero-length forward, right or up vector gives all-zero entries with
//   degenerate set in every group.
module look_at_view_matrix_unit
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int UW  = FRAC_BITS + 2;
    localparam int CW  = 2 * UW + 1;
    localparam int PW  = UW + COORD_W;
    localparam int DSW = PW + 3;

    typedef logic [2:0][UW-1:0]      t_unit3;
    typedef logic [2:0][COORD_W-1:0] t_eye3;

    typedef struct packed {
        t_eye3  eye;
        t_unit3 f;
    } t_side2;

    typedef struct packed {
        t_eye3  eye;
        t_unit3 f;
        t_unit3 r;
    } t_side3;

    typedef struct packed {
        t_unit3 r;
        t_unit3 u;
        t_unit3 f;
    } t_vecs;

    logic en;

    logic                     r_in_v;
    t_eye3                    r_eye;
    logic [2:0][COORD_W:0]    r_dir;

    t_flow  f1_in, f1_flow, f2_flow, f3_flow;
    t_unit3 f1_unit, f2_unit, f3_unit;
    t_eye3  f1_side;
    t_side2 s2_in, f2_side;
    t_side3 f3_side;
    t_unit3 rv;

    t_flow                  r_cp_flow;
    t_side3                 r_cp_side;
    logic [3:0][2*UW-1:0]   r_cp_p;
    t_flow                  r_cv_flow;
    t_side3                 r_cv_side;
    logic [2:0][CW-1:0]     r_cv;
    logic [2:0][CW-1:0]     n_cv;

    t_flow                  r_dp_flow;
    t_vecs                  r_dp_v;
    logic [2:0][2:0][PW-1:0] r_dp_p;
    t_flow                  r_ds_flow;
    t_vecs                  r_ds_v;
    logic [2:0][DSW-1:0]    r_ds;
    logic [2:0][DSW-1:0]    n_ds;
    t_flow                  r_dx_flow;
    t_vecs                  r_dx_v;
    logic [2:0][COORD_W-1:0] r_dx;
    logic [2:0][COORD_W-1:0] n_dx;

    logic                    r_full;
    logic [1:0]              r_grp;
    t_vecs                   r_hv;
    logic [2:0][COORD_W-1:0] r_hd;
    logic                    r_hok;

    assign en         = !r_full || (i_out_ready && (r_grp == GROUP_LAST));
    assign o_in_ready = en;

    // forward direction
    assign f1_in.valid = r_in_v;
    assign f1_in.ok    = 1'b1;

    lavm_unitize #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (COORD_W + 1),
        .SIDE_W    ($bits(t_eye3))
    ) u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_flow  (f1_in),
        .i_vec   (r_dir),
        .i_side  (r_eye),
        .o_flow  (f1_flow),
        .o_unit  (f1_unit),
        .o_side  (f1_side)
    );

    // right = f x (0,0,1)
    assign rv[0]   = f1_unit[1];
    assign rv[1]   = ~f1_unit[0] + 1'b1;
    assign rv[2]   = '0;
    assign s2_in.eye = f1_side;
    assign s2_in.f   = f1_unit;

    lavm_unitize #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (UW),
        .SIDE_W    ($bits(t_side2))
    ) u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_flow  (f1_flow),
        .i_vec   (rv),
        .i_side  (s2_in),
        .o_flow  (f2_flow),
        .o_unit  (f2_unit),
        .o_side  (f2_side)
    );

    // up = r x f, with r_z known to be zero
    always_comb begin
        logic signed [CW-1:0] p0, p1, p2, p3;
        p0 = CW'($signed(r_cp_p[0]));
        p1 = CW'($signed(r_cp_p[1]));
        p2 = CW'($signed(r_cp_p[2]));
        p3 = CW'($signed(r_cp_p[3]));
        n_cv[0] = p0;
        n_cv[1] = -p1;
        n_cv[2] = p2 - p3;
    end

    lavm_unitize #(
        .FRAC_BITS (FRAC_BITS),
        .IN_W      (CW),
        .SIDE_W    ($bits(t_side3))
    ) u_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_flow  (r_cv_flow),
        .i_vec   (r_cv),
        .i_side  (r_cv_side),
        .o_flow  (f3_flow),
        .o_unit  (f3_unit),
        .o_side  (f3_side)
    );

    // round half up, then negate and saturate where the matrix needs it
    always_comb begin
        logic signed [DSW-1:0] s;
        logic signed [DSW-1:0] half;
        half = DSW'(1) <<< (FRAC_BITS - 1);
        for (int v = 0; v < 3; v++) begin
            s = DSW'($signed(r_dp_p[v][0])) + DSW'($signed(r_dp_p[v][1]))
              + DSW'($signed(r_dp_p[v][2])) + half;
            n_ds[v] = s >>> FRAC_BITS;
        end
    end

    always_comb begin
        logic signed [DSW-1:0] d;
        for (int v = 0; v < 3; v++) begin
            d = $signed(r_ds[v]);
            if (v != 2) d = -d;
            if ((d[DSW-1:COORD_W-1] == '0) || (d[DSW-1:COORD_W-1] == '1)) begin
                n_dx[v] = d[COORD_W-1:0];
            end else if (d[DSW-1]) begin
                n_dx[v] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n_dx[v] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v          <= 1'b0;
            r_cp_flow.valid <= 1'b0;
            r_cv_flow.valid <= 1'b0;
            r_dp_flow.valid <= 1'b0;
            r_ds_flow.valid <= 1'b0;
            r_dx_flow.valid <= 1'b0;
            r_full          <= 1'b0;
            r_grp           <= '0;
        end else if (en) begin
            r_in_v   <= i_in_valid;
            r_eye[0] <= i_in_item.eye_x;
            r_eye[1] <= i_in_item.eye_y;
            r_eye[2] <= i_in_item.eye_z;
            r_dir[0] <= (COORD_W+1)'(i_in_item.target_x) - (COORD_W+1)'(i_in_item.eye_x);
            r_dir[1] <= (COORD_W+1)'(i_in_item.target_y) - (COORD_W+1)'(i_in_item.eye_y);
            r_dir[2] <= (COORD_W+1)'(i_in_item.target_z) - (COORD_W+1)'(i_in_item.eye_z);

            r_cp_flow     <= f2_flow;
            r_cp_side.eye <= f2_side.eye;
            r_cp_side.f   <= f2_side.f;
            r_cp_side.r   <= f2_unit;
            r_cp_p[0] <= (2*UW)'($signed(f2_unit[1]) * $signed(f2_side.f[2]));
            r_cp_p[1] <= (2*UW)'($signed(f2_unit[0]) * $signed(f2_side.f[2]));
            r_cp_p[2] <= (2*UW)'($signed(f2_unit[0]) * $signed(f2_side.f[1]));
            r_cp_p[3] <= (2*UW)'($signed(f2_unit[1]) * $signed(f2_side.f[0]));

            r_cv_flow <= r_cp_flow;
            r_cv_side <= r_cp_side;
            r_cv      <= n_cv;

            r_dp_flow  <= f3_flow;
            r_dp_v.r   <= f3_side.r;
            r_dp_v.u   <= f3_unit;
            r_dp_v.f   <= f3_side.f;
            for (int c = 0; c < 3; c++) begin
                r_dp_p[0][c] <= PW'($signed(f3_side.r[c]) * $signed(f3_side.eye[c]));
                r_dp_p[1][c] <= PW'($signed(f3_unit[c]) * $signed(f3_side.eye[c]));
                r_dp_p[2][c] <= PW'($signed(f3_side.f[c]) * $signed(f3_side.eye[c]));
            end

            r_ds_flow <= r_dp_flow;
            r_ds_v    <= r_dp_v;
            r_ds      <= n_ds;

            r_dx_flow <= r_ds_flow;
            r_dx_v    <= r_ds_v;
            r_dx      <= n_dx;

            // load the next item into the output register
            r_full <= r_dx_flow.valid;
            r_grp  <= '0;
            r_hv   <= r_dx_v;
            r_hd   <= r_dx;
            r_hok  <= r_dx_flow.ok;
        end else if (i_out_ready) begin
            r_grp <= r_grp + 2'd1;
        end
    end

    always_comb begin
        logic signed [COORD_W-1:0] fx;
        fx = COORD_W'($signed(r_hv.f[r_grp]));
        o_out_item.group_index = r_grp;
        o_out_item.last_group  = (r_grp == GROUP_LAST);
        o_out_item.degenerate  = !r_hok;
        if (r_grp == GROUP_LAST) begin
            o_out_item.value_0 = r_hd[0];
            o_out_item.value_1 = r_hd[1];
            o_out_item.value_2 = r_hd[2];
            o_out_item.value_3 = COORD_W'(1) <<< FRAC_BITS;
        end else begin
            o_out_item.value_0 = COORD_W'($signed(r_hv.r[r_grp]));
            o_out_item.value_1 = COORD_W'($signed(r_hv.u[r_grp]));
            o_out_item.value_2 = -fx;
            o_out_item.value_3 = '0;
        end
        if (!r_hok) begin
            o_out_item.value_0 = '0;
            o_out_item.value_1 = '0;
            o_out_item.value_2 = '0;
            o_out_item.value_3 = '0;
        end
    end

    assign o_out_valid = r_full;

`ifndef SYNTHESIS
    a_group_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && (o_out_item.group_index != GROUP_LAST)) |=>
        (o_out_valid &&
         (o_out_item.group_index == $past(o_out_item.group_index) + 2'd1)))
        else $error("output groups broken off or out of order");

    a_first_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_item.group_index == 2'd0))
        else $error("item started at a group other than zero");

    a_degen_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && (o_out_item.group_index != GROUP_LAST)) |=>
        (o_out_item.degenerate == $past(o_out_item.degenerate)))
        else $error("degenerate flag changed within an item");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.degenerate) |->
        ((o_out_item.value_0 == '0) && (o_out_item.value_1 == '0) &&
         (o_out_item.value_2 == '0) && (o_out_item.value_3 == '0)))
        else $error("degenerate item with non-zero entries");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output stalled");
`endif

endmodule

>>> test/tb_look_at_view_matrix_unit.sv
// Testbench for look_at_view_matrix_unit: directed and random eye/target items,
// each checked group by group against a behavioural predictor or all-zero degenerate groups.
// Depends on lavm_pkg and the look_at_view_matrix_unit RTL.
module tb_look_at_view_matrix_unit;
    import lavm_pkg::*;

    localparam int  FRAC       = FRAC_BITS_DEF;
    localparam longint ONE_Q   = 64'sd1 << FRAC;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  HOLD_LEN   = 300;
    localparam int  DRAIN_WAIT = 100;
    localparam int  N_RANDOM   = 190;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    t_out_item expected_groups[$];
    int        fail_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_request;

    look_at_view_matrix_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // scale to [2^29, 2^30), then divide by the integer length
    function automatic bit normalise(input longint v[3], output longint u[3]);
        longint unsigned mag[3];
        longint unsigned top;
        longint unsigned len;
        longint unsigned q;
        bit              neg[3];
        top = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > top) top = mag[i];
            u[i] = 0;
        end
        if (top == 0) return 1'b0;
        while (top >= (64'd1 << 30)) begin
            top >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (top < (64'd1 << 29)) begin
            top <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len = floor_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC) + (len >> 1)) / len;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] eye_dot(input longint a[3], input longint e[3], input bit negate);
        longint s;
        s = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
        s = (s + (64'sd1 << (FRAC - 1))) >>> FRAC;
        if (negate) s = -s;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    function automatic void push_groups(input logic [31:0] ent[16], input bit degen);
        t_out_item g;
        for (int k = 0; k < 4; k++) begin
            g.group_index = k[1:0];
            g.value_0     = ent[4 * k];
            g.value_1     = ent[4 * k + 1];
            g.value_2     = ent[4 * k + 2];
            g.value_3     = ent[4 * k + 3];
            g.last_group  = (k[1:0] == GROUP_LAST);
            g.degenerate  = degen;
            expected_groups.push_back(g);
        end
    endfunction

    function automatic void predict_view_matrix(input t_in_item it);
        longint      eye[3], fwd[3], f[3], rv[3], r[3], cv[3], u[3];
        logic [31:0] ent[16];
        bit          ok;
        eye[0] = it.eye_x;
        eye[1] = it.eye_y;
        eye[2] = it.eye_z;
        fwd[0] = longint'(it.target_x) - eye[0];
        fwd[1] = longint'(it.target_y) - eye[1];
        fwd[2] = longint'(it.target_z) - eye[2];
        for (int i = 0; i < 16; i++) ent[i] = '0;
        ok = normalise(fwd, f);
        if (ok) begin
            rv[0] = f[1];
            rv[1] = -f[0];
            rv[2] = 0;
            ok = normalise(rv, r);
        end
        if (ok) begin
            cv[0] = r[1] * f[2] - r[2] * f[1];
            cv[1] = r[2] * f[0] - r[0] * f[2];
            cv[2] = r[0] * f[1] - r[1] * f[0];
            ok = normalise(cv, u);
        end
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                ent[4 * i]     = r[i][31:0];
                ent[4 * i + 1] = u[i][31:0];
                ent[4 * i + 2] = 32'(-f[i]);
            end
            ent[12] = eye_dot(r, eye, 1'b1);
            ent[13] = eye_dot(u, eye, 1'b1);
            ent[14] = eye_dot(f, eye, 1'b0);
            ent[15] = ONE_Q[31:0];
        end
        push_groups(ent, !ok);
    endfunction

    task automatic offer_item(input t_in_item it, input bit fixed_degen);
        logic [31:0] zeros[16];
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (fixed_degen) begin
            foreach (zeros[i]) zeros[i] = '0;
            push_groups(zeros, 1'b1);
        end else begin
            predict_view_matrix(it);
        end
    endtask

    task automatic drain_results;
        i_in_valid <= 1'b0;
        while (expected_groups.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item random_item(input int kind);
        t_in_item it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case (kind)
            0: ; // full range
            1: begin
                // small scene near the origin
                it.eye_x    = $signed($urandom_range(20 * 65536)) - 10 * 65536;
                it.eye_y    = $signed($urandom_range(20 * 65536)) - 10 * 65536;
                it.eye_z    = $signed($urandom_range(20 * 65536)) - 10 * 65536;
                it.target_x = it.eye_x + $signed($urandom_range(8 * 65536)) - 4 * 65536;
                it.target_y = it.eye_y + $signed($urandom_range(8 * 65536)) - 4 * 65536;
                it.target_z = it.eye_z + $signed($urandom_range(8 * 65536)) - 4 * 65536;
            end
            2: begin
                it.target_x = it.eye_x;
                it.target_y = it.eye_y;
                it.target_z = it.eye_z;
            end
            3: begin
                it.target_x = it.eye_x;
                it.target_y = it.eye_y;
            end
            default: begin
                // nearly vertical view
                it.target_x = it.eye_x + $signed($urandom_range(6)) - 3;
                it.target_y = it.eye_y + $signed($urandom_range(6)) - 3;
            end
        endcase
        return it;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_LEN;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_groups.size() == 0) begin
                $error("unexpected group %0d", o_out_item.group_index);
                fail_count++;
            end else begin
                want = expected_groups.pop_front();
                if (o_out_item.group_index !== want.group_index) begin
                    $error("group_index exp %0d got %0d", want.group_index, o_out_item.group_index);
                    fail_count++;
                end
                if (o_out_item.value_0 !== want.value_0) begin
                    $error("value_0 exp %h got %h", want.value_0, o_out_item.value_0);
                    fail_count++;
                end
                if (o_out_item.value_1 !== want.value_1) begin
                    $error("value_1 exp %h got %h", want.value_1, o_out_item.value_1);
                    fail_count++;
                end
                if (o_out_item.value_2 !== want.value_2) begin
                    $error("value_2 exp %h got %h", want.value_2, o_out_item.value_2);
                    fail_count++;
                end
                if (o_out_item.value_3 !== want.value_3) begin
                    $error("value_3 exp %h got %h", want.value_3, o_out_item.value_3);
                    fail_count++;
                end
                if (o_out_item.last_group !== want.last_group) begin
                    $error("last_group exp %0b got %0b", want.last_group, o_out_item.last_group);
                    fail_count++;
                end
                if (o_out_item.degenerate !== want.degenerate) begin
                    $error("degenerate exp %0b got %0b", want.degenerate, o_out_item.degenerate);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL look_at_view_matrix_unit");
            $finish;
        end
    end

    typedef struct {
        t_in_item it;
        bit       fixed_degen;
    } t_row;

    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;
    localparam logic signed [31:0] QONE = 32'sh00010000;

    initial begin
        t_row rows[$];
        fail_count    = 0;
        cycle_count   = 0;
        hold_request  = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 72;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;

        // eye equals target, forward along z, then extremes and axes
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1});
        rows.push_back('{'{QMAX, QMIN, QMAX, QMAX, QMIN, QMAX}, 1'b1});
        rows.push_back('{'{0, 0, 0, 0, 0, 5 * QONE}, 1'b1});
        rows.push_back('{'{QMIN, QMIN, QMIN, QMIN, QMIN, QMAX}, 1'b1});
        rows.push_back('{'{QMAX, QMAX, QMAX, QMAX, QMAX, QMIN}, 1'b1});
        rows.push_back('{'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX}, 1'b0});
        rows.push_back('{'{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN}, 1'b0});
        rows.push_back('{'{QMAX, QMIN, 0, QMIN, QMAX, 0}, 1'b0});
        rows.push_back('{'{0, 0, 0, QONE, 0, 0}, 1'b0});
        rows.push_back('{'{0, 0, 0, 0, QONE, 0}, 1'b0});
        rows.push_back('{'{0, 0, 0, -QONE, -QONE, -QONE}, 1'b0});
        rows.push_back('{'{0, 0, 0, 1, 0, 0}, 1'b0});
        rows.push_back('{'{0, 0, 0, 1, 0, QMAX}, 1'b0});
        rows.push_back('{'{QMAX, QMAX, QMAX, QMAX - 1, QMAX - 1, QMAX - 1}, 1'b0});
        rows.push_back('{'{QMIN, QMIN, QMIN, QMIN + 1, QMIN + 1, QMIN + 1}, 1'b0});
        rows.push_back('{'{QMAX, QMIN, QMAX, QMAX, QMIN + 1, QMAX}, 1'b0});
        rows.push_back('{'{3 * QONE, 4 * QONE, 5 * QONE, 0, 0, 0}, 1'b0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) offer_item(rows[i].it, rows[i].fixed_degen);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                drain_results();
                send_idle_pct = 72;
                recv_idle_pct = 10;
            end else if (n == 2 * N_RANDOM / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request  = 1'b1;
            end
            offer_item(random_item($urandom_range(9) < 4 ? 0 : $urandom_range(4)), 1'b0);
        end
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS look_at_view_matrix_unit");
        end else begin
            $display("FAIL look_at_view_matrix_unit");
        end
        $finish;
    end

endmodule

>>> look_at_view_matrix_unit.f
rtl/lavm_pkg.sv
rtl/lavm_unitize.sv
rtl/look_at_view_matrix_unit.sv
test/tb_look_at_view_matrix_unit.sv
